// ===== rtl/core/set_assoc_lru_cache_tracker_macros.svh =====
// assertion macros used by the cache tracker back end rtl
// no dependencies
`ifndef SET_ASSOC_LRU_CACHE_TRACKER_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TRACKER_MACROS_SVH

// property must hold in the cycle after a trigger
`define SALC_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

// property must hold in the same cycle as a trigger
`define SALC_ASSERT_NOW(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/salc_pkg.sv =====
// package for the set-associative lru cache tracker
// types, constants and helpers used by every module but salc_ram; no dependencies
package salc_pkg;

   localparam int MAX_SET_BITS_DEF = 8;
   localparam int MAX_WAYS_DEF     = 8;

   // address width is fixed by the request transaction
   localparam int ADDR_W   = 48;
   localparam int TOTAL_W  = 32;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   localparam logic [3:0] RESET_SET_BITS    = 4'd4;
   localparam logic [5:0] RESET_OFFSET_BITS = 6'd4;
   localparam logic [3:0] RESET_WAYS        = 4'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               miss;
      logic               eviction;
      logic               second_hit;
      logic [TOTAL_W-1:0] hit_total;
      logic [TOTAL_W-1:0] miss_total;
      logic [TOTAL_W-1:0] eviction_total;
   } rsp_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

// ===== rtl/core/salc_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/salc_front.sv =====
// front end: accepts transactions, splits address into set and tag
// depends on salc_pkg
module salc_front #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                        start,
   output logic                        busy,
   input  salc_pkg::req_type           req_in,
   input  logic [3:0]                  set_bits,
   input  logic [5:0]                  offset_bits,
   input  logic                        q_full,
   output logic                        q_push,
   output logic [SET_W-1:0]            q_set,
   output logic [salc_pkg::ADDR_W-1:0] q_tag,
   output logic                        q_modify
);
   import salc_pkg::*;

   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] shifted;
   logic [6:0]        s_eff;
   logic [6:0]        tag_sh;

   assign busy   = q_full;
   assign q_push = start & ~q_full;

   always_comb begin
      addr = req_in.address;
      s_eff = (32'(set_bits) > MAX_SET_BITS) ? 7'(MAX_SET_BITS) : 7'(set_bits);
      tag_sh = s_eff + 7'(offset_bits);
      shifted = addr >> offset_bits;
      q_set = SET_W'(shifted & ((ADDR_W'(1) << s_eff) - ADDR_W'(1)));
      q_tag = (tag_sh >= 7'd64) ? '0 : addr >> tag_sh;
      q_modify = (req_in.kind == KIND_MODIFY);
   end
endmodule

// ===== rtl/core/salc_back.sv =====
// back end: read-modify-write of one set's tags, ages and valid bits, a read state then an update state
// depends on salc_pkg, salc_ram and the assertion macros
module salc_back #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
   parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  logic [SET_W-1:0]            q_set,
   input  logic [salc_pkg::ADDR_W-1:0] q_tag,
   input  logic                        q_modify,
   output logic                        q_pop,
   input  logic [3:0]                  ways,
   input  logic                        flush,
   output logic                        rsp_valid,
   output salc_pkg::rsp_type           rsp_out
);
   import salc_pkg::*;
   `include "set_assoc_lru_cache_tracker_macros.svh"

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SLOT_W = ADDR_W + AGE_W + 1;
   localparam int ROW_W  = MAX_WAYS * SLOT_W;

   typedef enum logic [1:0] {ST_CLEAR, ST_READ, ST_UPDATE} state_type;

   state_type          state_ff, state_in;
   logic [SET_W-1:0]   clr_ff, clr_in;
   logic [SET_W-1:0]   set_ff;
   logic [ADDR_W-1:0]  tag_ff;
   logic               modify_ff;
   logic [TOTAL_W-1:0] hits_ff, misses_ff, evicts_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [ROW_W-1:0] rd_row, wr_row, ram_wr_data;
   logic [SET_W-1:0] ram_wr_addr;
   logic             ram_we, upd_en, clearing, clear_last;

   logic [ADDR_W-1:0]   row_tag [MAX_WAYS];
   logic [AGE_W-1:0]    row_age [MAX_WAYS];
   logic [MAX_WAYS-1:0] row_vbit, row_valid, in_use, new_valid;
   logic [AGE_W-1:0]    new_age [MAX_WAYS];
   logic                hit, found, evict;
   logic [WAY_W-1:0]    target;
   logic [AGE_W-1:0]    ref_age;
   logic [4:0]          e_eff;
   logic [TOTAL_W-1:0]  hits_next;

   salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(q_set),
      .rd_data(rd_row)
   );

   // rows are zeroed one per cycle after reset and after every flush
   assign clearing    = (state_ff == ST_CLEAR);
   assign clear_last  = (clr_ff == SET_W'(SETS - 1));
   assign upd_en      = (state_ff == ST_UPDATE);
   assign q_pop       = (state_ff == ST_READ) & q_valid & ~flush;
   assign ram_we      = upd_en | clearing;
   assign ram_wr_addr = clearing ? clr_ff : set_ff;
   assign ram_wr_data = clearing ? '0 : wr_row;

   always_comb begin
      e_eff = (ways == 4'd0) ? 5'd1 :
              ((32'(ways) > MAX_WAYS) ? 5'(MAX_WAYS) : 5'(ways));
      hit = 1'b0; found = 1'b0; evict = 1'b0;
      target = '0; ref_age = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         row_tag[w]  = rd_row[w*SLOT_W +: ADDR_W];
         row_age[w]  = rd_row[w*SLOT_W+ADDR_W +: AGE_W];
         row_vbit[w] = rd_row[w*SLOT_W+ADDR_W+AGE_W];
         in_use[w]   = (w < 32'(e_eff));
         row_valid[w] = row_vbit[w] & in_use[w];
      end
      for (int w = MAX_WAYS-1; w >= 0; w--) begin
         if (row_valid[w] && row_tag[w] == tag_ff) begin
            hit = 1'b1; target = WAY_W'(w);
         end
      end
      if (!hit) begin
         for (int w = MAX_WAYS-1; w >= 0; w--) begin
            if (in_use[w] && !row_valid[w]) begin
               found = 1'b1; target = WAY_W'(w);
            end
         end
         if (!found) begin
            evict = 1'b1;
            ref_age = row_age[0]; target = '0;
            for (int w = 1; w < MAX_WAYS; w++) begin
               if (in_use[w] && row_age[w] > ref_age) begin
                  ref_age = row_age[w]; target = WAY_W'(w);
               end
            end
         end
      end else begin
         ref_age = row_age[target];
      end
      new_valid = row_vbit;
      for (int w = 0; w < MAX_WAYS; w++) begin
         new_age[w] = row_age[w];
         if (in_use[w]) begin
            if (hit || evict) begin
               if ((hit ? row_valid[w] : 1'b1) && row_age[w] < ref_age)
                  new_age[w] = row_age[w] + 1'b1;
            end else if (row_valid[w]) begin
               new_age[w] = row_age[w] + 1'b1;
            end
         end
         if (w == 32'(target)) begin
            new_age[w] = '0;
            new_valid[w] = 1'b1;
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         wr_row[w*SLOT_W +: ADDR_W] =
            (w == 32'(target) && !hit) ? tag_ff : row_tag[w];
         wr_row[w*SLOT_W+ADDR_W +: AGE_W] = new_age[w];
         wr_row[w*SLOT_W+ADDR_W+AGE_W] = new_valid[w];
      end
      hits_next = hit ? sat_inc(hits_ff) : hits_ff;
      if (modify_ff) hits_next = sat_inc(hits_next);
      case (state_ff)
         ST_CLEAR:  state_in = clear_last ? ST_READ : ST_CLEAR;
         ST_READ:   state_in = q_pop ? ST_UPDATE : ST_READ;
         ST_UPDATE: state_in = ST_READ;
         default:   state_in = ST_CLEAR;
      endcase
      if (flush) state_in = ST_CLEAR;
      clr_in = (clearing && !flush) ? clr_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         hits_ff <= '0; misses_ff <= '0; evicts_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= upd_en;
         if (q_pop) begin
            set_ff <= q_set; tag_ff <= q_tag; modify_ff <= q_modify;
         end
         if (upd_en) begin
            hits_ff <= hits_next;
            if (!hit) misses_ff <= sat_inc(misses_ff);
            if (evict) evicts_ff <= sat_inc(evicts_ff);
            rsp_ff.hit <= hit;
            rsp_ff.miss <= ~hit;
            rsp_ff.eviction <= evict;
            rsp_ff.second_hit <= modify_ff;
            rsp_ff.hit_total <= hits_next;
            rsp_ff.miss_total <= hit ? misses_ff : sat_inc(misses_ff);
            rsp_ff.eviction_total <= evict ? sat_inc(evicts_ff) : evicts_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   `SALC_ASSERT_NEXT(a_update_follows_read, q_pop, state_ff == ST_UPDATE, "no update after read")
   `SALC_ASSERT_NEXT(a_rsp_after_update, upd_en, rsp_valid, "missing response")
   `SALC_ASSERT_NOW(a_hit_miss_excl, rsp_valid, rsp_out.hit != rsp_out.miss, "hit and miss clash")
   `SALC_ASSERT_NOW(a_no_pop_clearing, clearing, !q_pop, "pop during clearing")
endmodule

// ===== rtl/core/salc_queue.sv =====
// short fifo of classified transactions between front and back end
// depends on salc_pkg
module salc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   import salc_pkg::*;

   logic [1:0][WIDTH-1:0] slot_ff;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0; rd_ptr_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end
endmodule

// ===== rtl/core/set_assoc_lru_cache_tracker.sv =====
// Tag-only set-associative LRU cache tracker. A transaction is taken when start
// is high and busy low; its result is driven on rsp_out with rsp_valid high for
// exactly one cycle and the receiver cannot hold it off. With the back end idle,
// a transaction goes from the queue through the read and update states to the
// rsp_valid and rsp_out registers. The back end does a read-modify-write of one
// set row in the tag/age/valid ram per transaction and takes no new one until
// the update is done; a two-entry queue lets the front accept while the back
// works, and busy is high only while that queue is full. After reset and after
// any csr write to a defined register, which invalidates all lines, the back end
// zeroes all 2**MAX_SET_BITS rows (256 by default), one per cycle, before the
// next transaction; transactions accepted meanwhile wait in the queue.
// depends on salc_pkg, salc_front, salc_queue, salc_back, salc_ram
module set_assoc_lru_cache_tracker #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  salc_pkg::req_type    req_in,
   output logic                 rsp_valid,
   output salc_pkg::rsp_type    rsp_out,
   input  logic                 csr_we,
   input  logic [salc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0] csr_data
);
   import salc_pkg::*;

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int QW    = SET_W + ADDR_W + 1;

   logic [3:0] set_bits_ff;
   logic [5:0] offset_bits_ff;
   logic [3:0] ways_ff;
   logic       flush;

   logic              q_full, q_push, q_valid, q_pop, f_modify, b_modify;
   logic [SET_W-1:0]  f_set, b_set;
   logic [ADDR_W-1:0] f_tag, b_tag;

   always_comb begin
      case (csr_index)
         CSR_SET_BITS, CSR_OFFSET_BITS, CSR_WAYS: flush = csr_we;
         default: flush = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= RESET_SET_BITS;
         offset_bits_ff <= RESET_OFFSET_BITS;
         ways_ff <= RESET_WAYS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff <= csr_data[3:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            CSR_WAYS:        ways_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
      .start(start), .busy(busy), .req_in(req_in),
      .set_bits(set_bits_ff), .offset_bits(offset_bits_ff), .q_full(q_full),
      .q_push(q_push), .q_set(f_set), .q_tag(f_tag), .q_modify(f_modify)
   );

   salc_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset), .push(q_push),
      .push_data({f_set, f_tag, f_modify}), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .pop_data({b_set, b_tag, b_modify})
   );

   salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_set(b_set),
      .q_tag(b_tag), .q_modify(b_modify), .q_pop(q_pop), .ways(ways_ff),
      .flush(flush), .rsp_valid(rsp_valid), .rsp_out(rsp_out)
   );
endmodule

// ===== dv/set_assoc_lru_cache_tracker_checker.sv =====
// checker for the set-associative lru cache tracker: tracks csr writes,
// predicts each access and compares every result; depends on salc_pkg
`timescale 1ns / 100ps

module set_assoc_lru_cache_tracker_checker
   import salc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_in,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_out,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    results_checked,
   output int                    hits_checked,
   output int                    evictions_checked
);

   localparam int SET_LIMIT = 8;
   localparam int WAY_LIMIT = 8;
   localparam int LINES     = (1 << SET_LIMIT) * WAY_LIMIT;

   logic              line_ok  [LINES];
   logic [ADDR_W-1:0] line_tag [LINES];
   logic [2:0]        line_rank[LINES];
   logic [TOTAL_W-1:0] hit_count, miss_count, evict_count;
   logic [3:0] cfg_set_bits, cfg_ways;
   logic [5:0] cfg_offset_bits;

   rsp_type expected_rsp[$];

   assign pending_count = expected_rsp.size();

   task automatic invalidate_lines();
      for (int i = 0; i < LINES; i++) begin
         line_ok[i]   = 1'b0;
         line_rank[i] = '0;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
   endtask

   task automatic model_access(input req_type r, output rsp_type p);
      int s, b, e, base, target, best;
      logic [63:0] addr, set_idx, tag;
      logic hit, evict, found;
      addr   = 64'(r.address);
      s      = (cfg_set_bits > SET_LIMIT) ? SET_LIMIT : cfg_set_bits;
      b      = cfg_offset_bits;
      e      = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_LIMIT) ? WAY_LIMIT : cfg_ways);
      hit    = 1'b0;
      evict  = 1'b0;
      found  = 1'b0;
      target = 0;
      set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
      tag     = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
      base    = int'(set_idx) * WAY_LIMIT;
      for (int w = 0; w < e; w++)
         if (!hit && line_ok[base+w] && 64'(line_tag[base+w]) == tag) begin
            hit    = 1'b1;
            target = w;
         end
      if (hit) begin
         best = line_rank[base+target];
         for (int w = 0; w < e; w++)
            if (line_ok[base+w] && line_rank[base+w] < best)
               line_rank[base+w]++;
         line_rank[base+target] = '0;
         hit_count = sat_inc(hit_count);
      end else begin
         for (int w = 0; w < e; w++)
            if (!found && !line_ok[base+w]) begin
               found  = 1'b1;
               target = w;
            end
         if (!found) begin
            // lowest way wins among equal oldest ranks
            best = line_rank[base];
            for (int w = 1; w < e; w++)
               if (line_rank[base+w] > best) begin
                  best   = line_rank[base+w];
                  target = w;
               end
            evict       = 1'b1;
            evict_count = sat_inc(evict_count);
            for (int w = 0; w < e; w++)
               if (w != target && line_rank[base+w] < best)
                  line_rank[base+w]++;
         end else begin
            for (int w = 0; w < e; w++)
               if (line_ok[base+w])
                  line_rank[base+w]++;
         end
         line_ok[base+target]   = 1'b1;
         line_tag[base+target]  = tag[ADDR_W-1:0];
         line_rank[base+target] = '0;
         miss_count = sat_inc(miss_count);
      end
      if (r.kind == KIND_MODIFY)
         hit_count = sat_inc(hit_count);
      p.hit            = hit;
      p.miss           = !hit;
      p.eviction       = evict;
      p.second_hit     = (r.kind == KIND_MODIFY);
      p.hit_total      = hit_count;
      p.miss_total     = miss_count;
      p.eviction_total = evict_count;
   endtask

   always @(posedge clock) begin
      rsp_type want, prediction;
      if (reset) begin
         invalidate_lines();
         hit_count       = '0;
         miss_count      = '0;
         evict_count     = '0;
         cfg_set_bits    = RESET_SET_BITS;
         cfg_offset_bits = RESET_OFFSET_BITS;
         cfg_ways        = RESET_WAYS;
         expected_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SET_BITS: begin
                  cfg_set_bits = csr_data[3:0];
                  invalidate_lines();
               end
               CSR_OFFSET_BITS: begin
                  cfg_offset_bits = csr_data;
                  invalidate_lines();
               end
               CSR_WAYS: begin
                  cfg_ways = csr_data[3:0];
                  invalidate_lines();
               end
               default: ;
            endcase
         end
         // the result of an older transaction is compared before a new one is modeled
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("result with no transaction outstanding", 64'd1, 64'd0);
            end else begin
               want = expected_rsp.pop_front();
               results_checked++;
               if (want.hit) hits_checked++;
               if (want.eviction) evictions_checked++;
               if (rsp_out.hit !== want.hit)
                  report_mismatch("hit", rsp_out.hit, want.hit);
               if (rsp_out.miss !== want.miss)
                  report_mismatch("miss", rsp_out.miss, want.miss);
               if (rsp_out.eviction !== want.eviction)
                  report_mismatch("eviction", rsp_out.eviction, want.eviction);
               if (rsp_out.second_hit !== want.second_hit)
                  report_mismatch("second_hit", rsp_out.second_hit, want.second_hit);
               if (rsp_out.hit_total !== want.hit_total)
                  report_mismatch("hit_total", rsp_out.hit_total, want.hit_total);
               if (rsp_out.miss_total !== want.miss_total)
                  report_mismatch("miss_total", rsp_out.miss_total, want.miss_total);
               if (rsp_out.eviction_total !== want.eviction_total)
                  report_mismatch("eviction_total", rsp_out.eviction_total,
                                  want.eviction_total);
            end
         end
         if (start && !busy) begin
            model_access(req_in, prediction);
            expected_rsp.push_back(prediction);
         end
      end
   end

   initial begin
      fail_count        = 0;
      results_checked   = 0;
      hits_checked      = 0;
      evictions_checked = 0;
   end

endmodule

// ===== dv/set_assoc_lru_cache_tracker_test.sv =====
// top of the cache tracker testbench: clock, reset, csr phases and access stimulus
// depends on salc_pkg, set_assoc_lru_cache_tracker and its checker
`timescale 1ns / 100ps

module set_assoc_lru_cache_tracker_test;
   import salc_pkg::*;

   localparam int STALL_LIMIT = 8000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 210;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_in = '0;
   logic rsp_valid;
   rsp_type rsp_out;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count, pending_count, results_checked, hits_checked, evictions_checked;
   int quiet_cycles = 0;
   int idle_pct;
   int cur_set_bits = 4, cur_offset_bits = 4;
   logic [ADDR_W-1:0] addr_pool[16];

   always #5 clock = ~clock;

   set_assoc_lru_cache_tracker DUT (
      .clock, .reset, .start, .busy, .req_in, .rsp_valid, .rsp_out,
      .csr_we, .csr_index, .csr_data
   );

   set_assoc_lru_cache_tracker_checker checker_inst (
      .clock, .reset, .start, .busy, .req_in, .rsp_valid, .rsp_out,
      .csr_we, .csr_index, .csr_data,
      .fail_count, .pending_count, .results_checked, .hits_checked,
      .evictions_checked
   );

   // watchdog: counts cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("set_assoc_lru_cache_tracker: mismatch");
         $finish;
      end
   end

   task automatic send_access(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
      int gap;
      req_in <= '{kind: kind, address: addr};
      start  <= 1'b1;
      do @(posedge clock); while (busy);
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // csr_we stays high across a burst and drops after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d,
                            input logic last);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      if (last) csr_we <= 1'b0;
   endtask

   // conflict-heavy pool: few tags over few sets
   task automatic fill_pool();
      logic [63:0] a;
      for (int i = 0; i < 16; i++) begin
         a = (64'($urandom_range(11)) << (cur_set_bits + cur_offset_bits))
           | (64'($urandom_range(3)) << cur_offset_bits)
           | (64'($urandom) & ((64'd1 << cur_offset_bits) - 64'd1));
         addr_pool[i] = a[ADDR_W-1:0];
      end
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 75) return addr_pool[$urandom_range(15)];
      return ADDR_W'({$urandom, $urandom});
   endfunction

   initial begin
      int sb[PHASES];
      int ob[PHASES];
      int wy[PHASES];
      sb = '{4, 0, 8, 2, 15, 3, 1, 8};
      ob = '{4, 0, 40, 6, 63, 5, 2, 0};
      wy = '{1, 1, 8, 4, 15, 0, 2, 8};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 84 : 38);
         if (ph > 0) begin
            drain();
            write_csr(CSR_SET_BITS, 6'(sb[ph]), 1'b0);
            write_csr(CSR_OFFSET_BITS, 6'(ob[ph]), 1'b0);
            write_csr(CSR_WAYS, 6'(wy[ph]), 1'b1);
         end
         cur_set_bits    = (sb[ph] > 8) ? 8 : sb[ph];
         cur_offset_bits = ob[ph];
         fill_pool();
         if (ph == 0) begin
            send_access(KIND_LOAD, '0);
            send_access(KIND_STORE, '0);
            send_access(KIND_MODIFY, '0);
            send_access(2'd3, '0);
            send_access(KIND_LOAD, '1);
            send_access(KIND_MODIFY, '1);
            send_access(KIND_LOAD, 48'h8000_0000_0000);
            send_access(KIND_STORE, 48'h0000_0000_000F);
            send_access(KIND_LOAD, 48'h0000_0000_0100);
            send_access(KIND_LOAD, 48'h0000_0000_0000);
            send_access(2'd3, 48'h5555_5555_5555);
            send_access(KIND_STORE, 48'hAAAA_AAAA_AAAA);
         end
         if (ph == 3) begin
            // fill then thrash one set past its ways to force lru evictions
            for (int i = 0; i < 12; i++)
               send_access(KIND_LOAD, 48'(i << (cur_set_bits + cur_offset_bits)));
            send_access(KIND_MODIFY, 48'(4 << (cur_set_bits + cur_offset_bits)));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_access(2'($urandom_range(3)), pick_address());
            if (ph == 2 && i == PHASE_ITEMS / 2) begin
               drain();
               // out-of-range index must leave the lines intact
               write_csr(2'd3, 6'($urandom), 1'b1);
            end
         end
      end
      drain();
      $display("covered %0d accesses over %0d csr settings: %0d hits, %0d evictions",
               results_checked, PHASES, hits_checked, evictions_checked);
      if (fail_count == 0)
         $display("set_assoc_lru_cache_tracker: match");
      else
         $display("set_assoc_lru_cache_tracker: mismatch");
      $finish;
   end

endmodule
